// File: sv/multilevel_priority_event_queue_core_assert.svh
`ifndef MULTILEVEL_PRIORITY_EVENT_QUEUE_CORE_ASSERT_SVH
`define MULTILEVEL_PRIORITY_EVENT_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge
`define MPEQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpeq: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the following edge
`define MPEQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpeq: next-cycle check failed");

`endif

// File: sv/mpeq_pkg.sv
package mpeq_pkg;

   // Default sizes of the queue
   localparam int NUM_LEVELS_DEF  = 8;
   localparam int LEVEL_DEPTH_DEF = 16;

   // Depth of the command queue between front and back
   localparam int CMD_DEPTH = 2;

   // Field widths
   localparam int ID_W     = 16;
   localparam int PRIO_W   = 4;
   localparam int TS_W     = 32;
   localparam int STATUS_W = 3;
   localparam int DATA_W   = 56;

   // Request kinds carried on tuser
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SERVE  = 1'b1;

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_SERVE,
      CMD_BAD
   } cmd_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_SERVED   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FULL     = 3'd3,
      ST_BADPRIO  = 3'd4
   } status_type;

   // Classified request handed from front to back
   typedef struct packed {
      cmd_kind_type       kind;
      logic [PRIO_W-1:0]  level;
      logic [ID_W-1:0]    id;
      logic [TS_W-1:0]    ts;
   } cmd_type;

   // One stored event
   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [TS_W-1:0] ts;
   } entry_type;

   typedef struct packed {
      status_type         status;
      logic [ID_W-1:0]    id;
      logic [PRIO_W-1:0]  prio;
      logic [TS_W-1:0]    ts;
   } result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SRV_WAIT,
      BK_INS_SCAN,
      BK_INS_PUT,
      BK_RESULT
   } back_state_type;

endpackage

// File: sv/mpeq_front.sv
module mpeq_front #(
   parameter int NUM_LEVELS = mpeq_pkg::NUM_LEVELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // event_id [15:0], priority_req [19:16], timestamp [51:20], zero pad [55:52]
   input  logic [mpeq_pkg::DATA_W-1:0] req_tdata,
   // opcode [0]
   input  logic                        req_tuser,
   output logic                        cmd_valid,
   output mpeq_pkg::cmd_type           cmd,
   input  logic                        cmd_pop
);

   localparam int PW   = $clog2(mpeq_pkg::CMD_DEPTH);
   localparam int FILW = $clog2(mpeq_pkg::CMD_DEPTH + 1);

   mpeq_pkg::cmd_type                 queue_ff [mpeq_pkg::CMD_DEPTH];
   logic [PW-1:0]                     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]                     rd_ptr_ff, rd_ptr_in;
   logic [FILW-1:0]                   fill_ff, fill_in;
   logic [mpeq_pkg::PRIO_W-1:0]       req_prio;
   logic                              bad_prio;
   logic                              push;
   mpeq_pkg::cmd_type                 new_cmd;

   // Classify the incoming request
   always_comb begin
      req_prio = req_tdata[mpeq_pkg::ID_W +: mpeq_pkg::PRIO_W];
      bad_prio = (req_prio == '0) || (int'(req_prio) > NUM_LEVELS);
      new_cmd.id    = req_tdata[mpeq_pkg::ID_W-1:0];
      new_cmd.ts    = req_tdata[mpeq_pkg::ID_W + mpeq_pkg::PRIO_W +: mpeq_pkg::TS_W];
      new_cmd.level = req_prio - mpeq_pkg::PRIO_W'(1);
      if (req_tuser == mpeq_pkg::OP_SERVE) begin
         new_cmd.kind = mpeq_pkg::CMD_SERVE;
      end else if (bad_prio) begin
         new_cmd.kind = mpeq_pkg::CMD_BAD;
      end else begin
         new_cmd.kind = mpeq_pkg::CMD_INSERT;
      end
   end

   // Command queue bookkeeping
   always_comb begin
      req_tready = (fill_ff != FILW'(mpeq_pkg::CMD_DEPTH));
      push       = req_tvalid && req_tready;
      wr_ptr_in  = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in  = cmd_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fill_in    = fill_ff + FILW'(push) - FILW'(cmd_pop);
      cmd_valid  = (fill_ff != '0);
      cmd        = queue_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the classified request
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// File: sv/mpeq_back.sv
module mpeq_back #(
   parameter int NUM_LEVELS  = mpeq_pkg::NUM_LEVELS_DEF,
   parameter int LEVEL_DEPTH = mpeq_pkg::LEVEL_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  mpeq_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // served_id [15:0], served_priority [19:16], served_timestamp [51:20], zero pad [55:52]
   output logic [mpeq_pkg::DATA_W-1:0]   rsp_tdata,
   // status [2:0]
   output logic [mpeq_pkg::STATUS_W-1:0] rsp_tuser
);

   localparam int LW      = $clog2(NUM_LEVELS);
   localparam int SW      = $clog2(LEVEL_DEPTH);
   localparam int CW      = $clog2(LEVEL_DEPTH + 1);
   localparam int ENTRIES = NUM_LEVELS * LEVEL_DEPTH;
   localparam int AW      = $clog2(ENTRIES);
   localparam int PAD_W   = mpeq_pkg::DATA_W - mpeq_pkg::ID_W - mpeq_pkg::PRIO_W
                            - mpeq_pkg::TS_W;

   // Event store: one ring of LEVEL_DEPTH slots per level
   mpeq_pkg::entry_type            store_ff [ENTRIES];
   mpeq_pkg::entry_type            rdata_ff;
   logic [CW-1:0]                  count_ff [NUM_LEVELS];
   logic [SW-1:0]                  head_ff  [NUM_LEVELS];

   mpeq_pkg::back_state_type       state_ff, state_in;
   mpeq_pkg::cmd_type              cmd_ff, cmd_in;
   logic [LW-1:0]                  lvl_ff, lvl_in;
   logic [SW-1:0]                  cur_head_ff, cur_head_in;
   logic [CW-1:0]                  cur_count_ff, cur_count_in;
   logic [CW-1:0]                  pos_ff, pos_in;
   mpeq_pkg::result_type           res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   mpeq_pkg::result_type           rsp_data_ff, rsp_data_in;

   logic                           found;
   logic [LW-1:0]                  enc_lvl;
   logic [LW-1:0]                  sel_lvl;
   logic [CW-1:0]                  sel_count;
   logic [SW-1:0]                  sel_head;
   logic [AW-1:0]                  rd_addr;
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   mpeq_pkg::entry_type            wr_data;
   mpeq_pkg::entry_type            new_entry;
   logic                           cnt_we;
   logic [CW-1:0]                  cnt_val;
   logic                           head_we;
   logic [SW-1:0]                  head_val;
   logic [LW-1:0]                  upd_lvl;

   // Map a position within a level's ring to a store address
   function automatic logic [AW-1:0] phys_addr(input logic [LW-1:0] lvl,
                                               input logic [SW-1:0] head,
                                               input logic [CW-1:0] logical);
      logic [CW:0]   sum;
      logic [AW-1:0] base;
      sum = (CW+1)'(head) + (CW+1)'(logical);
      if (sum >= (CW+1)'(LEVEL_DEPTH)) begin
         sum = sum - (CW+1)'(LEVEL_DEPTH);
      end
      base = AW'(lvl) * AW'(LEVEL_DEPTH);
      return base + AW'(sum[SW-1:0]);
   endfunction

   // Find the highest nonempty level
   always_comb begin
      found   = 1'b0;
      enc_lvl = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (count_ff[i] != '0) begin
            found   = 1'b1;
            enc_lvl = LW'(i);
         end
      end
   end

   // Pick the level the queued command works on
   always_comb begin
      sel_lvl   = (cmd.kind == mpeq_pkg::CMD_SERVE) ? enc_lvl : cmd.level[LW-1:0];
      sel_count = count_ff[sel_lvl];
      sel_head  = head_ff[sel_lvl];
   end

   // Sequencer: next state, store accesses and level updates
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      lvl_in       = lvl_ff;
      cur_head_in  = cur_head_ff;
      cur_count_in = cur_count_ff;
      pos_in       = pos_ff;
      res_in       = res_ff;
      cmd_pop      = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      new_entry.id = cmd_ff.id;
      new_entry.ts = cmd_ff.ts;
      wr_data      = new_entry;
      cnt_we       = 1'b0;
      cnt_val      = cur_count_ff;
      head_we      = 1'b0;
      head_val     = cur_head_ff;
      upd_lvl      = lvl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         mpeq_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop      = 1'b1;
               cmd_in       = cmd;
               lvl_in       = sel_lvl;
               cur_head_in  = sel_head;
               cur_count_in = sel_count;
               res_in       = '0;
               upd_lvl      = sel_lvl;
               case (cmd.kind)
                  mpeq_pkg::CMD_SERVE: begin
                     if (!found) begin
                        res_in.status = mpeq_pkg::ST_EMPTY;
                        state_in      = mpeq_pkg::BK_RESULT;
                     end else begin
                        // Read the head and retire it from the ring
                        rd_addr  = phys_addr(sel_lvl, sel_head, '0);
                        head_we  = 1'b1;
                        head_val = (sel_head == SW'(LEVEL_DEPTH - 1)) ? '0
                                                                      : sel_head + SW'(1);
                        cnt_we   = 1'b1;
                        cnt_val  = sel_count - CW'(1);
                        state_in = mpeq_pkg::BK_SRV_WAIT;
                     end
                  end
                  mpeq_pkg::CMD_INSERT: begin
                     if (sel_count == CW'(LEVEL_DEPTH)) begin
                        res_in.status = mpeq_pkg::ST_FULL;
                        state_in      = mpeq_pkg::BK_RESULT;
                     end else if (sel_count == '0) begin
                        wr_en         = 1'b1;
                        wr_addr       = phys_addr(sel_lvl, sel_head, '0);
                        wr_data.id    = cmd.id;
                        wr_data.ts    = cmd.ts;
                        cnt_we        = 1'b1;
                        cnt_val       = CW'(1);
                        res_in.status = mpeq_pkg::ST_INSERTED;
                        state_in      = mpeq_pkg::BK_RESULT;
                     end else begin
                        // Start the walk from the tail
                        rd_addr  = phys_addr(sel_lvl, sel_head, sel_count - CW'(1));
                        pos_in   = sel_count;
                        state_in = mpeq_pkg::BK_INS_SCAN;
                     end
                  end
                  default: begin
                     res_in.status = mpeq_pkg::ST_BADPRIO;
                     state_in      = mpeq_pkg::BK_RESULT;
                  end
               endcase
            end
         end

         mpeq_pkg::BK_SRV_WAIT: begin
            res_in.status = mpeq_pkg::ST_SERVED;
            res_in.id     = rdata_ff.id;
            res_in.ts     = rdata_ff.ts;
            res_in.prio   = mpeq_pkg::PRIO_W'(lvl_ff) + mpeq_pkg::PRIO_W'(1);
            state_in      = mpeq_pkg::BK_RESULT;
         end

         mpeq_pkg::BK_INS_SCAN: begin
            if (rdata_ff.ts > cmd_ff.ts) begin
               // Move the later entry up one slot into the hole
               wr_en   = 1'b1;
               wr_addr = phys_addr(lvl_ff, cur_head_ff, pos_ff);
               wr_data = rdata_ff;
               pos_in  = pos_ff - CW'(1);
               if (pos_ff == CW'(1)) begin
                  state_in = mpeq_pkg::BK_INS_PUT;
               end else begin
                  rd_addr = phys_addr(lvl_ff, cur_head_ff, pos_ff - CW'(2));
               end
            end else begin
               // Drop the new event into the hole behind equal timestamps
               wr_en         = 1'b1;
               wr_addr       = phys_addr(lvl_ff, cur_head_ff, pos_ff);
               cnt_we        = 1'b1;
               cnt_val       = cur_count_ff + CW'(1);
               res_in.status = mpeq_pkg::ST_INSERTED;
               state_in      = mpeq_pkg::BK_RESULT;
            end
         end

         mpeq_pkg::BK_INS_PUT: begin
            wr_en         = 1'b1;
            wr_addr       = phys_addr(lvl_ff, cur_head_ff, pos_ff);
            cnt_we        = 1'b1;
            cnt_val       = cur_count_ff + CW'(1);
            res_in.status = mpeq_pkg::ST_INSERTED;
            state_in      = mpeq_pkg::BK_RESULT;
         end

         mpeq_pkg::BK_RESULT: begin
            // Hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = mpeq_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = mpeq_pkg::BK_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpeq_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cnt_we) begin
            count_ff[upd_lvl] <= cnt_val;
         end
         if (head_we) begin
            head_ff[upd_lvl] <= head_val;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      lvl_ff       <= lvl_in;
      cur_head_ff  <= cur_head_in;
      cur_count_ff <= cur_count_in;
      pos_ff       <= pos_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Event store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= store_ff[rd_addr];
   end

   // Drive the result channel
   always_comb begin
      rsp_tvalid = rsp_valid_ff;
      rsp_tuser  = rsp_data_ff.status;
      rsp_tdata  = {{PAD_W{1'b0}}, rsp_data_ff.ts, rsp_data_ff.prio, rsp_data_ff.id};
   end

endmodule

// File: sv/multilevel_priority_event_queue_core.sv
// Priority event queue with NUM_LEVELS levels of LEVEL_DEPTH events each. Every
// request gets exactly one result, in request order. An insert (tuser 0) places
// the event in its level sorted by timestamp, behind any equal timestamps; a
// serve (tuser 1) returns the earliest event of the highest nonempty level.
// Requests pass through a two-entry command queue into a sequencer that owns an
// event store (one write and one registered read per cycle), and results leave
// through an output register, so the request side keeps taking work, until the
// command queue fills, while a result waits. A bad priority, a full level, an
// empty queue or an insert into an empty level go straight to the result; a
// serve waits for the registered store read; other inserts move each later
// entry of the level up one slot, one entry per cycle through the store port,
// which sets the insert time. No clearing is needed after reset.
module multilevel_priority_event_queue_core #(
   parameter int NUM_LEVELS  = mpeq_pkg::NUM_LEVELS_DEF,
   parameter int LEVEL_DEPTH = mpeq_pkg::LEVEL_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // event_id [15:0], priority_req [19:16], timestamp [51:20], zero pad [55:52]
   input  logic [mpeq_pkg::DATA_W-1:0]   req_tdata,
   // opcode [0]
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // served_id [15:0], served_priority [19:16], served_timestamp [51:20], zero pad [55:52]
   output logic [mpeq_pkg::DATA_W-1:0]   rsp_tdata,
   // status [2:0]
   output logic [mpeq_pkg::STATUS_W-1:0] rsp_tuser
);

   logic              cmd_valid;
   logic              cmd_pop;
   mpeq_pkg::cmd_type cmd;

   mpeq_front #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   mpeq_back #(
      .NUM_LEVELS  (NUM_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: sv/mpeq_checker.sv
`include "multilevel_priority_event_queue_core_assert.svh"

module mpeq_checker #(
   parameter int NUM_LEVELS = mpeq_pkg::NUM_LEVELS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [mpeq_pkg::DATA_W-1:0]   rsp_tdata,
   input logic [mpeq_pkg::STATUS_W-1:0] rsp_tuser
);

   // A stalled result holds
   `MPEQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Status is one of the defined codes
   `MPEQ_ASSERT_IMP(a_status_range, clock, reset, rsp_tvalid, rsp_tuser <= mpeq_pkg::ST_BADPRIO)

   // Anything but a served event carries zero payload
   `MPEQ_ASSERT_IMP(a_idle_payload, clock, reset, rsp_tvalid && (rsp_tuser != mpeq_pkg::ST_SERVED), rsp_tdata == '0)

   // A served event comes from a real level
   `MPEQ_ASSERT_IMP(a_served_level, clock, reset, rsp_tvalid && (rsp_tuser == mpeq_pkg::ST_SERVED), (rsp_tdata[19:16] != '0) && (int'(rsp_tdata[19:16]) <= NUM_LEVELS))

endmodule

bind multilevel_priority_event_queue_core mpeq_checker #(
   .NUM_LEVELS (NUM_LEVELS)
) u_mpeq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
